/* design/clsr_pkg.sv */
`timescale 1ns / 1ps

package clsr_pkg;

	localparam int MAX_ROWS = 2;
	localparam int MAX_COLS = 16;
	localparam int NCELLS = MAX_ROWS * MAX_COLS;
	localparam int CELL_W = (NCELLS > 1) ? $clog2(NCELLS) : 1;
	localparam int ROW_IW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COL_IW = $clog2(MAX_COLS);

	localparam int OP_W = 3;
	localparam int ROWS_W = 2;
	localparam int COLS_W = 5;
	localparam int CHAR_W = 8;
	localparam int KIND_W = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W = 5;

	localparam logic [CHAR_W-1:0] SPACE_CODE = 8'h20;

	localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
	localparam logic [OP_W-1:0] OP_CLEAR = 3'd1;
	localparam logic [OP_W-1:0] OP_INV_ALL = 3'd2;
	localparam logic [OP_W-1:0] OP_INV_CODE = 3'd3;
	localparam logic [OP_W-1:0] OP_FLUSH = 3'd4;

	localparam logic [KIND_W-1:0] KIND_DONE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CURSOR = 2'd1;
	localparam logic [KIND_W-1:0] KIND_WRITE = 2'd2;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IMM = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [ROWS_W-1:0] row;
		logic [COLS_W-1:0] col;
		logic [CHAR_W-1:0] char_code;
	} in_item_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ROWS_W-1:0] out_row;
		logic [COLS_W-1:0] out_col;
		logic [CHAR_W-1:0] out_char;
		logic last;
		logic any_dirty;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic write_cell;
		logic scan_init;
		logic scan_next;
		logic run_set;
		logic run_clr;
		logic sweep_clear;
		logic sweep_mark;
		logic clean_cell;
		logic any_calc;
		logic emit;
		logic [KIND_W-1:0] kind;
	} dp_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic imm;
		logic dirty;
		logic match;
		logic in_run;
		logic last_cell;
		logic out_ready;
	} dp_stat_t;

endpackage

/* design/clsr_dp.sv */
`timescale 1ns / 1ps

module clsr_dp (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [clsr_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [clsr_pkg::CFG_W-1:0] cfg_data,
	input clsr_pkg::in_item_t in_data,
	input logic out_stall,
	output logic out_valid,
	output clsr_pkg::out_item_t out_data,
	input clsr_pkg::dp_cmd_t cmd,
	output clsr_pkg::dp_stat_t st
);
	import clsr_pkg::*;

	logic [ROWS_W-1:0] rows_q;
	logic [COLS_W-1:0] cols_q;
	logic imm_q;
	logic [OP_W-1:0] op_q;
	logic [CHAR_W-1:0] code_q;
	logic [ROW_IW-1:0] r_q;
	logic [COL_IW-1:0] c_q;
	logic run_q;
	logic any_q;
	logic [CHAR_W-1:0] shadow_q [NCELLS];
	logic [NCELLS-1:0] dirty_q;
	logic out_valid_q;
	out_item_t out_q;

	logic [ROWS_W-1:0] nr;
	logic [COLS_W-1:0] nc;
	logic [ROWS_W-1:0] row_cl;
	logic [COLS_W-1:0] col_cl;
	logic [CELL_W-1:0] cur_idx;
	logic [CHAR_W-1:0] cur_char;
	logic last_col;
	logic last_row;
	logic out_ready;
	logic [NCELLS-1:0] range_mask;
	out_item_t nxt_item;

	always_comb begin
		if (rows_q == '0)
			nr = ROWS_W'(1);
		else if (rows_q > ROWS_W'(MAX_ROWS))
			nr = ROWS_W'(MAX_ROWS);
		else
			nr = rows_q;
		if (cols_q == '0)
			nc = COLS_W'(1);
		else if (cols_q > COLS_W'(MAX_COLS))
			nc = COLS_W'(MAX_COLS);
		else
			nc = cols_q;
	end

	always_comb begin
		if (in_data.row == '0)
			row_cl = ROWS_W'(1);
		else if (in_data.row > nr)
			row_cl = nr;
		else
			row_cl = in_data.row;
		if (in_data.col == '0)
			col_cl = COLS_W'(1);
		else if (in_data.col > nc)
			col_cl = nc;
		else
			col_cl = in_data.col;
	end

	always_comb begin
		for (int i = 0; i < NCELLS; i++) begin
			range_mask[i] = (ROWS_W'(i / MAX_COLS) < nr) && (COLS_W'(i % MAX_COLS) < nc);
		end
	end

	assign cur_idx = CELL_W'(int'(r_q) * MAX_COLS + int'(c_q));
	assign cur_char = shadow_q[cur_idx];
	assign last_col = (COLS_W'(c_q) + COLS_W'(1)) == nc;
	assign last_row = (ROWS_W'(r_q) + ROWS_W'(1)) == nr;
	assign out_ready = !out_valid_q || !out_stall;

	always_comb begin
		st.op = op_q;
		st.imm = imm_q;
		st.dirty = dirty_q[cur_idx];
		st.match = (cur_char == code_q);
		st.in_run = run_q;
		st.last_cell = last_col && last_row;
		st.out_ready = out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_W'(2);
			cols_q <= COLS_W'(16);
			imm_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROWS: rows_q <= cfg_data[ROWS_W-1:0];
				CFG_COLS: cols_q <= cfg_data[COLS_W-1:0];
				CFG_IMM: imm_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= '0;
			code_q <= '0;
			r_q <= '0;
			c_q <= '0;
			run_q <= 1'b0;
			any_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				op_q <= in_data.op;
				code_q <= in_data.char_code;
				r_q <= ROW_IW'(row_cl - ROWS_W'(1));
				c_q <= COL_IW'(col_cl - COLS_W'(1));
			end
			if (cmd.scan_init) begin
				r_q <= '0;
				c_q <= '0;
				run_q <= 1'b0;
			end
			if (cmd.scan_next) begin
				if (last_col) begin
					c_q <= '0;
					r_q <= r_q + ROW_IW'(1);
					run_q <= 1'b0;
				end else begin
					c_q <= c_q + COL_IW'(1);
				end
			end
			if (cmd.run_set)
				run_q <= 1'b1;
			if (cmd.run_clr)
				run_q <= 1'b0;
			if (cmd.any_calc)
				any_q <= |(dirty_q & range_mask);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCELLS; i++)
				shadow_q[i] <= SPACE_CODE;
			dirty_q <= '1;
		end else begin
			if (cmd.write_cell && (cur_char != code_q)) begin
				shadow_q[cur_idx] <= code_q;
				dirty_q[cur_idx] <= 1'b1;
			end
			if (cmd.sweep_clear) begin
				shadow_q[cur_idx] <= SPACE_CODE;
				dirty_q[cur_idx] <= 1'b0;
			end
			if (cmd.sweep_mark)
				dirty_q[cur_idx] <= 1'b1;
			if (cmd.clean_cell)
				dirty_q[cur_idx] <= 1'b0;
		end
	end

	always_comb begin
		nxt_item = '0;
		nxt_item.kind = cmd.kind;
		case (cmd.kind)
			KIND_CURSOR: begin
				nxt_item.out_row = ROWS_W'(r_q) + ROWS_W'(1);
				nxt_item.out_col = COLS_W'(c_q) + COLS_W'(1);
			end
			KIND_WRITE: nxt_item.out_char = cur_char;
			KIND_DONE: begin
				nxt_item.last = 1'b1;
				nxt_item.any_dirty = any_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit)
			out_q <= nxt_item;
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	a_clean_only_dirty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clean_cell |-> dirty_q[cur_idx])
		else $error("cleaning a cell that is not dirty");
	a_write_cleans: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.kind == KIND_WRITE) |=> !dirty_q[$past(cur_idx)])
		else $error("written cell still dirty");
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> out_ready)
		else $error("beat emitted over a held beat");

endmodule

/* design/clsr_ctrl.sv */
`timescale 1ns / 1ps

module clsr_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input clsr_pkg::dp_stat_t st,
	output clsr_pkg::dp_cmd_t cmd
);
	import clsr_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_SWEEP,
		S_ANY,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.kind = KIND_DONE;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (st.op)
					OP_WRITE: begin
						cmd.write_cell = 1'b1;
						if (st.imm) begin
							cmd.scan_init = 1'b1;
							state_d = S_SCAN;
						end else begin
							state_d = S_ANY;
						end
					end
					OP_CLEAR: begin
						if (st.out_ready) begin
							cmd.emit = 1'b1;
							cmd.kind = KIND_CLEAR;
							cmd.scan_init = 1'b1;
							state_d = S_SWEEP;
						end
					end
					OP_INV_ALL, OP_INV_CODE: begin
						cmd.scan_init = 1'b1;
						state_d = S_SWEEP;
					end
					OP_FLUSH: begin
						cmd.scan_init = 1'b1;
						state_d = S_SCAN;
					end
					default: state_d = S_ANY;
				endcase
			end
			S_SWEEP: begin
				cmd.sweep_clear = (st.op == OP_CLEAR);
				cmd.sweep_mark = (st.op == OP_INV_ALL) || ((st.op == OP_INV_CODE) && st.match);
				cmd.scan_next = 1'b1;
				if (st.last_cell)
					state_d = S_ANY;
			end
			S_SCAN: begin
				if (!st.dirty) begin
					cmd.run_clr = 1'b1;
					cmd.scan_next = 1'b1;
					if (st.last_cell)
						state_d = S_ANY;
				end else if (!st.in_run) begin
					if (st.out_ready) begin
						cmd.emit = 1'b1;
						cmd.kind = KIND_CURSOR;
						cmd.run_set = 1'b1;
					end
				end else if (st.out_ready) begin
					cmd.emit = 1'b1;
					cmd.kind = KIND_WRITE;
					cmd.clean_cell = 1'b1;
					cmd.scan_next = 1'b1;
					if (st.last_cell)
						state_d = S_ANY;
				end
			end
			S_ANY: begin
				cmd.any_calc = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (st.out_ready) begin
					cmd.emit = 1'b1;
					cmd.kind = KIND_DONE;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_DISPATCH))
		else $error("accepted beat not dispatched");
	a_run_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.run_set && cmd.scan_next))
		else $error("run start and advance in one cycle");
	a_write_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.kind == KIND_WRITE) |-> st.in_run)
		else $error("character beat without cursor beat");
	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.kind == KIND_DONE) |=> (state_q == S_IDLE))
		else $error("done beat did not end the item");

endmodule

/* design/char_lcd_dirty_shadow_refresher_unit.sv */
`timescale 1ns / 1ps

// Shadow store and dirty-cell refresher for a character LCD.
// Input channel in_valid/in_stall/in_data carries one operation per beat:
// write char, clear, invalidate all, invalidate by code, flush.
// Output channel out_valid/out_stall/out_data carries display commands
// (clear, set cursor, write char) followed by one done beat with last set.
// One item is worked at a time; in_stall stays high until the done beat is
// loaded into the output register. A write char without flush passes
// through dispatch, the dirty-summary step and the done beat; clear and
// invalidation first sweep the cells in range, and flush scans them and
// sends a cursor beat before each dirty run; both visit one cell at a time.
// When the receiver raises out_stall the held beat stays put and the
// scan waits at its next beat until the output register frees up.
// Reset fills every cell with a space, marks every cell dirty and sets
// the size to 2 rows by 16 columns with immediate flush off.
// cfg_we/cfg_index/cfg_data write the size and mode registers; the user
// must write them only while idle, which the block does not enforce.

module char_lcd_dirty_shadow_refresher_unit (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [clsr_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [clsr_pkg::CFG_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input clsr_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output clsr_pkg::out_item_t out_data
);
	import clsr_pkg::*;

	dp_cmd_t cmd;
	dp_stat_t st;

	clsr_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.st(st),
		.cmd(cmd)
	);

	clsr_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_data(in_data),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_data(out_data),
		.cmd(cmd),
		.st(st)
	);

endmodule

/* verif/char_lcd_dirty_shadow_refresher_unit_tb.sv */
`timescale 1ns / 1ps

module char_lcd_dirty_shadow_refresher_unit_tb;
	import clsr_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 10;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;

	char_lcd_dirty_shadow_refresher_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	logic [CHAR_W-1:0] shadow_chars [MAX_ROWS][MAX_COLS];
	bit dirty_map [MAX_ROWS][MAX_COLS];
	int rows_cfg;
	int cols_cfg;
	bit imm_cfg;

	out_item_t pending_cmds[$];
	out_item_t want;

	int idle_pct;
	int stall_pct;
	int mismatches;
	int beats_checked;
	int quiet_cycles;
	int size_settings;
	int op_count [2**OP_W];

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	function automatic int active_rows();
		int r;
		r = rows_cfg;
		if (r < 1) r = 1;
		if (r > MAX_ROWS) r = MAX_ROWS;
		return r;
	endfunction

	function automatic int active_cols();
		int c;
		c = cols_cfg;
		if (c < 1) c = 1;
		if (c > MAX_COLS) c = MAX_COLS;
		return c;
	endfunction

	function automatic int clamp_pos(int v, int hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic void push_cmd(logic [KIND_W-1:0] kind, int r, int c,
			logic [CHAR_W-1:0] ch, bit last, bit any);
		out_item_t cmd;
		cmd.kind = kind;
		cmd.out_row = r[ROWS_W-1:0];
		cmd.out_col = c[COLS_W-1:0];
		cmd.out_char = ch;
		cmd.last = last;
		cmd.any_dirty = any;
		pending_cmds.push_back(cmd);
	endfunction

	function automatic bit any_cell_dirty();
		for (int r = 0; r < active_rows(); r++)
			for (int c = 0; c < active_cols(); c++)
				if (dirty_map[r][c]) return 1'b1;
		return 1'b0;
	endfunction

	function automatic void flush_cells();
		bit in_run;
		for (int r = 0; r < active_rows(); r++) begin
			in_run = 1'b0;
			for (int c = 0; c < active_cols(); c++) begin
				if (dirty_map[r][c]) begin
					if (!in_run) begin
						push_cmd(KIND_CURSOR, r + 1, c + 1, '0, 1'b0, 1'b0);
						in_run = 1'b1;
					end
					push_cmd(KIND_WRITE, 0, 0, shadow_chars[r][c], 1'b0, 1'b0);
					dirty_map[r][c] = 1'b0;
				end else begin
					in_run = 1'b0;
				end
			end
		end
	endfunction

	function automatic void apply_to_shadow(in_item_t it);
		int nr;
		int nc;
		int r;
		int c;
		nr = active_rows();
		nc = active_cols();
		op_count[it.op]++;
		case (it.op)
			OP_WRITE: begin
				r = clamp_pos(it.row, nr) - 1;
				c = clamp_pos(it.col, nc) - 1;
				if (shadow_chars[r][c] != it.char_code) begin
					shadow_chars[r][c] = it.char_code;
					dirty_map[r][c] = 1'b1;
				end
				if (imm_cfg) flush_cells();
			end
			OP_CLEAR: begin
				push_cmd(KIND_CLEAR, 0, 0, '0, 1'b0, 1'b0);
				for (int i = 0; i < nr; i++)
					for (int j = 0; j < nc; j++) begin
						shadow_chars[i][j] = SPACE_CODE;
						dirty_map[i][j] = 1'b0;
					end
			end
			OP_INV_ALL, OP_INV_CODE: begin
				for (int i = 0; i < nr; i++)
					for (int j = 0; j < nc; j++)
						if (it.op == OP_INV_ALL || shadow_chars[i][j] == it.char_code)
							dirty_map[i][j] = 1'b1;
			end
			OP_FLUSH: flush_cells();
			default: ;
		endcase
		push_cmd(KIND_DONE, 0, 0, '0, 1'b1, any_cell_dirty());
	endfunction

	function automatic void check_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			beats_checked++;
			if (pending_cmds.size() == 0) begin
				$error("unexpected beat: kind %0d, row %0d, col %0d, char %0d",
					out_data.kind, out_data.out_row, out_data.out_col, out_data.out_char);
				mismatches++;
			end else begin
				want = pending_cmds.pop_front();
				check_field("kind", want.kind, out_data.kind);
				check_field("out_row", want.out_row, out_data.out_row);
				check_field("out_col", want.out_col, out_data.out_col);
				check_field("out_char", want.out_char, out_data.out_char);
				check_field("last", want.last, out_data.last);
				check_field("any_dirty", want.any_dirty, out_data.any_dirty);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_op(input logic [OP_W-1:0] op, input int row, input int col,
			input int ch);
		in_item_t it;
		it.op = op;
		it.row = row[ROWS_W-1:0];
		it.col = col[COLS_W-1:0];
		it.char_code = ch[CHAR_W-1:0];
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		apply_to_shadow(it);
		@(negedge clk);
	endtask

	// drop valid and wait until every command of the last item is out
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_cmds.size() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_size_mode(input int rows, input int cols, input bit imm);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= CFG_ROWS;
		cfg_data <= rows[CFG_W-1:0];
		@(negedge clk);
		cfg_index <= CFG_COLS;
		cfg_data <= cols[CFG_W-1:0];
		@(negedge clk);
		cfg_index <= CFG_IMM;
		cfg_data <= {{(CFG_W-1){1'b0}}, imm};
		@(negedge clk);
		cfg_we <= 1'b0;
		rows_cfg = rows & 3;
		cols_cfg = cols & 31;
		imm_cfg = imm;
		size_settings++;
		@(negedge clk);
	endtask

	task automatic test_reset_state();
		send_op(OP_FLUSH, 0, 0, 0);
		send_op(OP_FLUSH, 0, 0, 0);
	endtask

	task automatic test_write_clamp();
		send_op(OP_WRITE, 0, 0, 8'h41);
		send_op(OP_WRITE, 3, 31, 8'hFF);
		send_op(OP_WRITE, 1, 1, 8'h41);
		send_op(OP_WRITE, 2, 8, 8'h00);
		send_op(OP_WRITE, 1, 2, int'(SPACE_CODE));
		send_op(OP_WRITE, 1, 17, 8'h5A);
		send_op(OP_FLUSH, 0, 0, 0);
		for (int k = OP_FLUSH + 1; k < 2**OP_W; k++)
			send_op(k[OP_W-1:0], 3, 31, 8'hFF);
	endtask

	task automatic test_clear_invalidate();
		send_op(OP_CLEAR, 0, 0, 0);
		send_op(OP_INV_CODE, 0, 0, int'(SPACE_CODE));
		send_op(OP_FLUSH, 0, 0, 0);
		send_op(OP_WRITE, 1, 4, 8'h41);
		send_op(OP_WRITE, 2, 9, 8'h41);
		send_op(OP_FLUSH, 0, 0, 0);
		send_op(OP_INV_CODE, 0, 0, 8'h41);
		send_op(OP_FLUSH, 0, 0, 0);
		send_op(OP_INV_ALL, 0, 0, 0);
		send_op(OP_FLUSH, 0, 0, 0);
	endtask

	task automatic test_immediate_flush();
		set_size_mode(2, 16, 1'b1);
		send_op(OP_WRITE, 2, 16, 8'h7E);
		send_op(OP_WRITE, 2, 16, 8'h7E);
		send_op(OP_INV_CODE, 0, 0, 8'h7E);
		send_op(OP_WRITE, 1, 1, 8'h80);
	endtask

	task automatic test_size_limits();
		set_size_mode(1, 1, 1'b0);
		send_op(OP_WRITE, 3, 31, 8'h31);
		send_op(OP_INV_ALL, 0, 0, 0);
		send_op(OP_FLUSH, 0, 0, 0);
		set_size_mode(0, 0, 1'b0);
		send_op(OP_FLUSH, 0, 0, 0);
		set_size_mode(3, 31, 1'b0);
		send_op(OP_FLUSH, 0, 0, 0);
		set_size_mode(2, 8, 1'b1);
		send_op(OP_WRITE, 2, 12, 8'h55);
		send_op(OP_CLEAR, 0, 0, 0);
		set_size_mode(2, 16, 1'b0);
		send_op(OP_FLUSH, 0, 0, 0);
	endtask

	task automatic random_size_mode();
		int cols;
		cols = ($urandom_range(0, 1) != 0) ? 16 : $urandom_range(0, 31);
		set_size_mode($urandom_range(0, 3), cols, $urandom_range(0, 3) == 0);
	endtask

	task automatic test_random_traffic(input int n_items, input int idle, input int stall);
		int sel;
		int col;
		int ch;
		logic [OP_W-1:0] op;
		idle_pct = idle;
		stall_pct = stall;
		random_size_mode();
		for (int i = 0; i < n_items; i++) begin
			if (i % 40 == 39) random_size_mode();
			sel = $urandom_range(0, 99);
			if (sel < 55) op = OP_WRITE;
			else if (sel < 68) op = OP_FLUSH;
			else if (sel < 73) op = OP_CLEAR;
			else if (sel < 80) op = OP_INV_ALL;
			else if (sel < 93) op = OP_INV_CODE;
			else op = OP_W'($urandom_range(OP_FLUSH + 1, 2**OP_W - 1));
			col = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 17) : $urandom_range(0, 31);
			case ($urandom_range(0, 5))
				0: ch = int'(SPACE_CODE);
				1, 2: ch = 8'h41 + $urandom_range(0, 2);
				default: ch = $urandom_range(0, 255);
			endcase
			send_op(op, $urandom_range(0, 3), col, ch);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		idle_pct = 25;
		stall_pct = 72;
		mismatches = 0;
		beats_checked = 0;
		quiet_cycles = 0;
		size_settings = 0;
		foreach (op_count[k]) op_count[k] = 0;
		foreach (shadow_chars[r, c]) begin
			shadow_chars[r][c] = SPACE_CODE;
			dirty_map[r][c] = 1'b1;
		end
		rows_cfg = 2;
		cols_cfg = 16;
		imm_cfg = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_state();
		test_write_clamp();
		test_clear_invalidate();
		test_immediate_flush();
		test_size_limits();
		test_random_traffic(165, 25, 72);
		test_random_traffic(165, 72, 25);
		test_random_traffic(165, 0, 0);

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d writes, %0d clears, %0d invalidate-all, %0d invalidate-by-code,",
			op_count[OP_WRITE], op_count[OP_CLEAR], op_count[OP_INV_ALL],
			op_count[OP_INV_CODE]);
		$display("%0d flushes, %0d unused opcodes, %0d size settings, %0d beats checked",
			op_count[OP_FLUSH], op_count[5] + op_count[6] + op_count[7], size_settings,
			beats_checked);
		if (mismatches == 0 && pending_cmds.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
